@@ hdl/tcce_pkg.sv @@
// shared types and constants of the text console character engine
`default_nettype none

package tcce_pkg;

   // default screen geometry
   localparam int SCREEN_WIDTH_DEF  = 80;
   localparam int SCREEN_HEIGHT_DEF = 25;
   localparam int TAB_STEP_DEF      = 2;

   // cell contents after reset, and the null character
   localparam logic [7:0] RESET_ATTR = 8'h07;
   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] NULL_CHAR  = 8'h00;

   // control characters
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;

   // item modes
   localparam logic [1:0] MODE_PUT  = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_SET  = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
      logic [6:0] col;
      logic [4:0] row;
   } req_item_type;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear_step;
      logic scroll_step;
      logic exec_put;
      logic exec_set;
      logic read_issue;
      logic wr_zero;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] mode;
      logic       ctrl_char;
      logic       scroll_need;
      logic       sweep_last;
   } sts_type;

endpackage

`default_nettype wire

@@ hdl/tcce_ram.sv @@
// screen cell memory, one write port and one registered read port
`default_nettype none

module tcce_ram
   import tcce_pkg::*;
#(
   parameter int DEPTH = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [15:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered: data follows in the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/tcce_ctrl.sv @@
// sequencing controller of the text console character engine
`default_nettype none

module tcce_ctrl
   import tcce_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_DRAIN,
      ST_ZERO,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (sts.mode)
               MODE_PUT: begin
                  cmd.exec_put = 1'b1;
                  if (sts.scroll_need) begin
                     state_in = ST_SCROLL;
                  end else if (sts.ctrl_char) begin
                     state_in = ST_ZERO;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               MODE_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = ST_RESP;
               end
               MODE_SET: begin
                  cmd.exec_set = 1'b1;
                  state_in     = ST_RESP;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last copy write lands this cycle
            state_in = sts.ctrl_char ? ST_ZERO : ST_RESP;
         end
         ST_ZERO: begin
            cmd.wr_zero = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/tcce_dp.sv @@
// datapath: cursor, attribute, item registers, screen memory and sweep counter
`default_nettype none

module tcce_dp
   import tcce_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int TAB_STEP      = TAB_STEP_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_item_type req_item,
   output logic              rsp_strobe,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data,
   input  wire cmd_type      cmd,
   output sts_type           sts
);

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CW         = $clog2(SCREEN_WIDTH);
   localparam int RW         = $clog2(SCREEN_HEIGHT);
   localparam int CW1        = CW + 1;
   localparam int RW1        = RW + 1;

   function automatic logic [AW-1:0] lin_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(r) * AW'(SCREEN_WIDTH) + AW'(c);
   endfunction

   // item registers
   logic [1:0]    it_mode_ff;
   logic [7:0]    it_char_ff;
   logic [CW-1:0] it_col_ff;
   logic [RW-1:0] it_row_ff;

   // cursor and attribute
   logic [CW-1:0] cur_col_ff;
   logic [RW-1:0] cur_row_ff;
   logic [7:0]    attr_ff;

   // sweep counter for clearing and scrolling
   logic [AW-1:0] idx_ff;
   logic          pend_ff;
   logic [AW-1:0] pend_addr_ff;
   logic          pend_keep_ff;

   // response registers
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;

   // memory ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;

   logic          ctrl_char;
   logic          idx_last;
   logic          idx_in_copy;
   logic [AW-1:0] cur_addr;
   logic [CW1-1:0] col_mv;
   logic [RW1-1:0] row_mv;
   logic [CW1-1:0] col_st;
   logic [RW1-1:0] row_st;
   logic          scroll_need;

   assign ctrl_char   = (it_char_ff == CH_NEWLINE) || (it_char_ff == CH_TAB)
                        || (it_char_ff == CH_BACKSPACE);
   assign idx_last    = (idx_ff == AW'(CELL_COUNT - 1));
   assign idx_in_copy = (idx_ff < AW'(CELL_COUNT - SCREEN_WIDTH));
   assign cur_addr    = lin_addr(cur_row_ff, cur_col_ff);

   // cursor movement of a put, then wrap to the next row
   always_comb begin
      col_mv = {1'b0, cur_col_ff};
      row_mv = {1'b0, cur_row_ff};
      if (it_char_ff == CH_NEWLINE) begin
         row_mv = row_mv + 1'b1;
         col_mv = '0;
      end else if (it_char_ff == CH_TAB) begin
         col_mv = col_mv + CW1'(TAB_STEP);
      end else if (it_char_ff == CH_BACKSPACE) begin
         if (cur_col_ff != '0) begin
            col_mv = col_mv - 1'b1;
         end else if (cur_row_ff != '0) begin
            row_mv = row_mv - 1'b1;
            col_mv = CW1'(SCREEN_WIDTH - 1);
         end
      end else begin
         col_mv = col_mv + 1'b1;
      end
      if (col_mv >= CW1'(SCREEN_WIDTH)) begin
         col_st = col_mv - CW1'(SCREEN_WIDTH);
         row_st = row_mv + 1'b1;
      end else begin
         col_st = col_mv;
         row_st = row_mv;
      end
      scroll_need = (row_st >= RW1'(SCREEN_HEIGHT));
   end

   // item capture with clamping to the screen
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         it_mode_ff <= req_item.mode;
         it_char_ff <= req_item.char_code;
         it_col_ff  <= ({1'b0, req_item.col} >= 8'(SCREEN_WIDTH)) ?
                       CW'(SCREEN_WIDTH - 1) : CW'(req_item.col);
         it_row_ff  <= ({2'b0, req_item.row} >= 7'(SCREEN_HEIGHT)) ?
                       RW'(SCREEN_HEIGHT - 1) : RW'(req_item.row);
      end
   end

   // cursor and attribute registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         attr_ff    <= RESET_ATTR;
      end else begin
         if (cmd.exec_put) begin
            cur_col_ff <= col_st[CW-1:0];
            cur_row_ff <= scroll_need ? RW'(SCREEN_HEIGHT - 1) : row_st[RW-1:0];
         end else if (cmd.exec_set) begin
            cur_col_ff <= it_col_ff;
            cur_row_ff <= it_row_ff;
         end
         if (csr_valid) begin
            attr_ff <= csr_data;
         end
      end
   end

   assign csr_ready = 1'b1;

   // sweep counter and pending copy write
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.clear_step || cmd.scroll_step) begin
            idx_ff <= idx_last ? '0 : idx_ff + 1'b1;
         end
         pend_ff <= cmd.scroll_step;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= idx_ff;
      pend_keep_ff <= !idx_in_copy;
   end

   // read address: source cell while scrolling, else the requested cell
   assign rd_addr = cmd.scroll_step ?
                    (idx_in_copy ? idx_ff + AW'(SCREEN_WIDTH) : idx_ff) :
                    lin_addr(it_row_ff, it_col_ff);

   // write port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = {attr_ff, it_char_ff};
      priority if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = {RESET_ATTR, BLANK_CHAR};
      end else if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = pend_keep_ff ? {rd_data[15:8], NULL_CHAR} : rd_data;
      end else if (cmd.exec_put && !ctrl_char) begin
         wr_en   = 1'b1;
      end else if (cmd.wr_zero) begin
         wr_en   = 1'b1;
         wr_data = {attr_ff, NULL_CHAR};
      end else begin
         wr_en   = 1'b0;
      end
   end

   tcce_ram #(
      .DEPTH (CELL_COUNT),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_item_ff.cursor_pos <= 11'(cur_addr);
         rsp_item_ff.cell_char  <= (it_mode_ff == MODE_READ) ? rd_data[7:0] : 8'h00;
         rsp_item_ff.cell_attr  <= (it_mode_ff == MODE_READ) ? rd_data[15:8] : 8'h00;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   // status to the controller
   assign sts.mode        = it_mode_ff;
   assign sts.ctrl_char   = ctrl_char;
   assign sts.scroll_need = scroll_need;
   assign sts.sweep_last  = idx_last;

endmodule

`default_nettype wire

@@ hdl/text_console_character_engine_core.sv @@
// Text console character engine: a character screen with a cursor.
//
// Items enter on req_item and are taken at a clock edge with start high
// and busy low. Each item gives one result on rsp_item, shown for one cycle
// with rsp_strobe high; the receiver has no way to hold it off.
// Modes: put a character, read a cell, set the cursor.
// After acceptance an item passes EXEC and then RESP, which loads the
// registered result strobe; newline, tab and backspace pass ZERO between
// the two for the null write. busy drops in the same cycle the strobe
// shows, so no new item is taken before the result of the last one.
// A put that moves past the bottom row scrolls the screen: one cell per
// cycle through the memory in SCROLL, then DRAIN for the last copy write.
// After reset busy stays high while every cell is cleared to a space with
// attribute 0x07. The attribute register is written on the csr channel,
// which is always ready; write it only while no item is in flight.
`default_nettype none

module text_console_character_engine_core
   import tcce_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int TAB_STEP      = TAB_STEP_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_item,
   output logic              rsp_strobe,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencing
   tcce_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // screen, cursor and response
   tcce_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TAB_STEP      (TAB_STEP)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

@@ verif/tcce_console_checker.sv @@
// checker for the text console engine: screen predictor and result comparison
`timescale 1ns / 1ps

module tcce_console_checker
   import tcce_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         busy,
   input  wire req_item_type req_item,
   input  wire logic         rsp_strobe,
   input  wire rsp_item_type rsp_item,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [7:0]   csr_data,
   output int                fail_count,
   output int                outstanding
);

   localparam int W     = SCREEN_WIDTH_DEF;
   localparam int H     = SCREEN_HEIGHT_DEF;
   localparam int TAB   = TAB_STEP_DEF;
   localparam int CELLS = W * H;

   // shadow copy of the screen, cursor and attribute
   logic [15:0]  screen [0:CELLS-1];
   int           cur_row;
   int           cur_col;
   logic [7:0]   attr;
   rsp_item_type console_expect_q [$];
   int           mismatch_count;

   initial begin
      fail_count     = 0;
      outstanding    = 0;
      mismatch_count = 0;
   end

   function automatic void clear_console();
      int i;
      for (i = 0; i < CELLS; i++) begin
         screen[i] = {RESET_ATTR, BLANK_CHAR};
      end
      cur_row = 0;
      cur_col = 0;
      attr    = RESET_ATTR;
   endfunction

   function automatic void place_glyph(logic [7:0] ch);
      screen[cur_row * W + cur_col] = {attr, ch};
   endfunction

   // rows move up one line, bottom row keeps attributes with null characters
   function automatic void scroll_up();
      int i;
      for (i = 0; i + W < CELLS; i++) begin
         screen[i] = screen[i + W];
      end
      for (i = CELLS - W; i < CELLS; i++) begin
         screen[i] = {screen[i][15:8], NULL_CHAR};
      end
   endfunction

   function automatic void settle_cursor();
      if (cur_col >= W) begin
         cur_col -= W;
         cur_row++;
      end
      if (cur_row >= H) begin
         scroll_up();
         cur_row = H - 1;
      end
   endfunction

   function automatic void put_glyph(logic [7:0] ch);
      if (ch == CH_NEWLINE || ch == CH_TAB || ch == CH_BACKSPACE) begin
         if (ch == CH_NEWLINE) begin
            cur_row++;
            cur_col = 0;
         end else if (ch == CH_TAB) begin
            cur_col += TAB;
         end else if (cur_col > 0) begin
            cur_col--;
         end else if (cur_row > 0) begin
            cur_row--;
            cur_col = W - 1;
         end
         settle_cursor();
         place_glyph(NULL_CHAR);
      end else begin
         place_glyph(ch);
         cur_col++;
         settle_cursor();
      end
   endfunction

   // apply one item to the shadow console and return the expected result
   function automatic rsp_item_type advance_console(req_item_type item);
      rsp_item_type res;
      int           c;
      int           r;
      int           pos;
      logic [15:0]  cell_word;
      c   = (item.col >= W) ? W - 1 : int'(item.col);
      r   = (item.row >= H) ? H - 1 : int'(item.row);
      res = '0;
      case (item.mode)
         MODE_PUT: begin
            put_glyph(item.char_code);
         end
         MODE_READ: begin
            cell_word     = screen[r * W + c];
            res.cell_char = cell_word[7:0];
            res.cell_attr = cell_word[15:8];
         end
         MODE_SET: begin
            cur_col = c;
            cur_row = r;
         end
         default: begin
         end
      endcase
      pos            = cur_row * W + cur_col;
      res.cursor_pos = pos[10:0];
      return res;
   endfunction

   // watch the channels at each edge
   always @(posedge clock) begin
      rsp_item_type exp_item;
      if (reset) begin
         clear_console();
         console_expect_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            attr = csr_data;
         end
         if (start && !busy) begin
            console_expect_q.push_back(advance_console(req_item));
         end
         if (rsp_strobe) begin
            if (console_expect_q.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result with no item pending: pos %0d char %02h attr %02h",
                           $realtime, rsp_item.cursor_pos, rsp_item.cell_char,
                           rsp_item.cell_attr);
               end
            end else begin
               exp_item = console_expect_q.pop_front();
               if (rsp_item.cursor_pos !== exp_item.cursor_pos ||
                   rsp_item.cell_char !== exp_item.cell_char ||
                   rsp_item.cell_attr !== exp_item.cell_attr) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch exp pos %0d char %02h attr %02h got %0d %02h %02h",
                              $realtime, exp_item.cursor_pos, exp_item.cell_char,
                              exp_item.cell_attr, rsp_item.cursor_pos,
                              rsp_item.cell_char, rsp_item.cell_attr);
                  end
               end
            end
         end
      end
      outstanding <= console_expect_q.size();
   end

endmodule

@@ verif/tb_text_console_character_engine_core.sv @@
// testbench top for the text console engine: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_text_console_character_engine_core;
   import tcce_pkg::*;

   localparam int PHASE_ITEMS = 170;
   localparam int PHASE_COUNT = 5;
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int REQ_BITS    = $bits(req_item_type);

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         start     = 1'b0;
   logic         busy;
   req_item_type req_item  = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data  = 8'h00;
   int           fail_count;
   int           outstanding;
   int           cycle_count = 0;

   text_console_character_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   tcce_console_checker console_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL text_console_character_engine_core");
         $finish;
      end
   end

   function automatic req_item_type make_req(logic [1:0] mode, logic [7:0] ch,
                                             logic [6:0] col, logic [4:0] row);
      req_item_type item;
      item.mode      = mode;
      item.char_code = ch;
      item.col       = col;
      item.row       = row;
      return item;
   endfunction

   // random item: mostly puts, with control characters, reads, cursor moves and the unused mode mixed in
   function automatic req_item_type random_req();
      req_item_type item;
      int           pick;
      item = req_item_type'(REQ_BITS'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         item.mode = MODE_PUT;
         pick      = $urandom_range(0, 99);
         if (pick < 15) item.char_code = CH_NEWLINE;
         else if (pick < 25) item.char_code = CH_TAB;
         else if (pick < 40) item.char_code = CH_BACKSPACE;
      end else if (pick < 80) begin
         item.mode = MODE_READ;
      end else if (pick < 95) begin
         item.mode = MODE_SET;
         // aim some moves at the screen edges
         pick = $urandom_range(0, 9);
         if (pick < 2) item.row = 5'd24;
         else if (pick < 3) item.row = 5'd0;
         pick = $urandom_range(0, 9);
         if (pick < 2) item.col = 7'd79;
         else if (pick < 3) item.col = 7'd0;
      end else begin
         item.mode = 2'd3;
      end
      return item;
   endfunction

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // present one item and hold it until the block takes it
   task automatic send_item(req_item_type item, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
   endtask

   // let every pending result come back before touching the register
   task automatic drain_console();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_attribute(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_item_type directed_q [$];
      logic [7:0]   attr_plan [PHASE_COUNT];
      int           p;
      int           n;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, extremes, control characters, scroll, clamping
      directed_q.push_back(make_req(MODE_READ, 8'h00, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_READ, 8'h00, 7'd127, 5'd31));
      directed_q.push_back(make_req(MODE_PUT, 8'h41, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_PUT, 8'h00, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_PUT, 8'hFF, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_PUT, CH_TAB, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_PUT, CH_NEWLINE, 7'd0, 5'd0));
      // backspace at start of a row goes to the end of the row above
      directed_q.push_back(make_req(MODE_PUT, CH_BACKSPACE, 7'd0, 5'd0));
      // backspace at the home position stays there
      directed_q.push_back(make_req(MODE_SET, 8'h00, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_PUT, CH_BACKSPACE, 7'd0, 5'd0));
      // out of range move clamps to the bottom right cell
      directed_q.push_back(make_req(MODE_SET, 8'hFF, 7'd127, 5'd31));
      directed_q.push_back(make_req(MODE_PUT, 8'h5A, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_READ, 8'h00, 7'd0, 5'd24));
      // tab past the last column wraps with the excess
      directed_q.push_back(make_req(MODE_SET, 8'h00, 7'd79, 5'd10));
      directed_q.push_back(make_req(MODE_PUT, CH_TAB, 7'd0, 5'd0));
      // newline on the bottom row scrolls
      directed_q.push_back(make_req(MODE_SET, 8'h00, 7'd5, 5'd24));
      directed_q.push_back(make_req(MODE_PUT, CH_NEWLINE, 7'd0, 5'd0));
      directed_q.push_back(make_req(2'd3, 8'hFF, 7'd127, 5'd31));
      directed_q.push_back(make_req(MODE_SET, 8'h00, 7'd78, 5'd24));
      directed_q.push_back(make_req(MODE_PUT, CH_TAB, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_READ, 8'h00, 7'd78, 5'd23));
      directed_q.push_back(make_req(MODE_READ, 8'h00, 7'd0, 5'd0));
      directed_q.push_back(make_req(MODE_PUT, 8'h7F, 7'd0, 5'd0));
      foreach (directed_q[i]) begin
         send_item(directed_q[i], (i < 8) ? 0 : pick_gap());
      end

      // random phases, each under its own attribute
      attr_plan[0] = 8'h00;
      attr_plan[1] = 8'hFF;
      attr_plan[2] = 8'($urandom);
      attr_plan[3] = 8'h1E;
      attr_plan[4] = 8'($urandom);
      for (p = 0; p < PHASE_COUNT; p++) begin
         drain_console();
         write_attribute(attr_plan[p]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // a stretch without idling at the top of each hundred
            send_item(random_req(), ((n % 100) < 20) ? 0 : pick_gap());
         end
      end
      start <= 1'b0;

      // wait out the remaining results
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS text_console_character_engine_core");
      end else begin
         $display("FAIL text_console_character_engine_core");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/tcce_pkg.sv
hdl/tcce_ram.sv
hdl/tcce_ctrl.sv
hdl/tcce_dp.sv
hdl/text_console_character_engine_core.sv
verif/tcce_console_checker.sv
verif/tb_text_console_character_engine_core.sv
